>>> sv/sierpinski_carpet_pixel_top_macros.svh
// Assertion macros for the carpet pixel pipeline.
`ifndef SIERPINSKI_CARPET_PIXEL_TOP_MACROS_SVH
`define SIERPINSKI_CARPET_PIXEL_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define SCP_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define SCP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/scp_pkg.sv
// Shared types, constants and helpers for the carpet pixel pipeline.
package scp_pkg;

  localparam int DEF_WIDTH     = 1024;
  localparam int DEF_HEIGHT    = 1024;
  localparam int DEF_MAX_DEPTH = 16;

  localparam int PIX_W      = 10;
  localparam int COLOR_W    = 24;
  localparam int PAL_IDX_W  = 4;
  localparam int PAL_DEPTH  = 16;
  localparam int DEPTH_W    = 4;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 2;
  // integer part of |Q16.16|, up to 2^15
  localparam int INT_W      = 16;
  // pixel minus half size, half size up to 2048
  localparam int DIFF_W     = 13;
  localparam int PROD_W     = DIFF_W + CFG_W + 1;

  // floor(x/3) = (x * RECIP3) >> RECIP3_SHIFT, exact for x < 2^16
  localparam int               RECIP3_SHIFT = 17;
  localparam logic [RECIP3_SHIFT-1:0] RECIP3 = 17'd43691;

  localparam logic [CFG_W-1:0] STEP_RESET   = 32'd128;
  localparam logic [CFG_W-1:0] OFFSET_RESET = 32'd0;
  localparam logic [COLOR_W-1:0] BLACK      = 24'h000000;

  typedef enum logic {
    CMD_RENDER    = 1'b0,
    CMD_PAL_WRITE = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_X   = 2'd0,
    REG_STEP_Y   = 2'd1,
    REG_OFFSET_X = 2'd2,
    REG_OFFSET_Y = 2'd3
  } reg_idx_t;

  typedef struct packed {
    cmd_t                 command;
    logic [PIX_W-1:0]     pixel_x;
    logic [PIX_W-1:0]     pixel_y;
    logic [PAL_IDX_W-1:0] palette_index;
    logic [COLOR_W-1:0]   palette_color;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0]   out_x;
    logic [PIX_W-1:0]   out_y;
    logic [COLOR_W-1:0] color;
    logic               hit;
    logic [DEPTH_W-1:0] hit_depth;
  } out_t;

  // one item in flight through the digit stages
  typedef struct packed {
    in_t                req;
    logic [INT_W-1:0]   ix;
    logic [INT_W-1:0]   iy;
    logic               done;
    logic               hit;
    logic [DEPTH_W-1:0] depth;
  } dig_t;

  function automatic logic [INT_W-1:0] div3_q(input logic [INT_W-1:0] x);
    logic [INT_W+RECIP3_SHIFT-1:0] p;
    p = (INT_W+RECIP3_SHIFT)'(x) * (INT_W+RECIP3_SHIFT)'(RECIP3);
    return p[INT_W+RECIP3_SHIFT-1:RECIP3_SHIFT];
  endfunction

endpackage

>>> sv/scp_map.sv
// Two-stage coordinate map: pixel to scaled plane point, then saturated integer magnitude.
module scp_map import scp_pkg::*; #(
  parameter int WIDTH  = DEF_WIDTH,
  parameter int HEIGHT = DEF_HEIGHT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  in_t              in_req,
  input  logic [CFG_W-1:0] step_x,
  input  logic [CFG_W-1:0] step_y,
  input  logic [CFG_W-1:0] offset_x,
  input  logic [CFG_W-1:0] offset_y,
  output logic             out_valid,
  output dig_t             out_dig
);

  localparam logic signed [DIFF_W-1:0] HALF_X = $signed(DIFF_W'(WIDTH / 2));
  localparam logic signed [DIFF_W-1:0] HALF_Y = $signed(DIFF_W'(HEIGHT / 2));

  function automatic logic [INT_W-1:0] plane_int(
    input logic signed [PROD_W-1:0] prod,
    input logic        [CFG_W-1:0]  off
  );
    logic signed [PROD_W:0] sum;
    logic [CFG_W-1:0]       v;
    logic [CFG_W-1:0]       mag;
    sum = (PROD_W+1)'(prod) + (PROD_W+1)'($signed(off));
    // upper bits all equal to sign means the value fits in 32 bits
    if (&sum[PROD_W:CFG_W-1] || ~|sum[PROD_W:CFG_W-1]) begin
      v = sum[CFG_W-1:0];
    end else begin
      v = sum[PROD_W] ? {1'b1, {(CFG_W-1){1'b0}}} : {1'b0, {(CFG_W-1){1'b1}}};
    end
    mag = v[CFG_W-1] ? (~v + 1'b1) : v;
    return mag[CFG_W-1:CFG_W-INT_W];
  endfunction

  logic signed [DIFF_W-1:0] dx, dy;
  logic signed [PROD_W-1:0] prod_x_next, prod_y_next;

  logic                     a_valid;
  in_t                      a_req;
  logic signed [PROD_W-1:0] a_prod_x, a_prod_y;

  assign dx = $signed({{(DIFF_W-PIX_W){1'b0}}, in_req.pixel_x}) - HALF_X;
  assign dy = $signed({{(DIFF_W-PIX_W){1'b0}}, in_req.pixel_y}) - HALF_Y;
  assign prod_x_next = PROD_W'(dx) * PROD_W'($signed({1'b0, step_x}));
  assign prod_y_next = PROD_W'(dy) * PROD_W'($signed({1'b0, step_y}));

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      a_valid   <= in_valid;
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_req         <= in_req;
      a_prod_x      <= prod_x_next;
      a_prod_y      <= prod_y_next;
      out_dig.req   <= a_req;
      out_dig.ix    <= plane_int(a_prod_x, offset_x);
      out_dig.iy    <= plane_int(a_prod_y, offset_y);
      out_dig.done  <= 1'b0;
      out_dig.hit   <= 1'b0;
      out_dig.depth <= '0;
    end
  end

endmodule

>>> sv/scp_digit.sv
// One base-3 digit test stage of the carpet pipeline.
module scp_digit import scp_pkg::*; #(
  parameter int DIGIT = 0
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  dig_t in_dig,
  output logic out_valid,
  output dig_t out_dig
);

  localparam logic [DEPTH_W-1:0] DIGIT_CODE = DEPTH_W'(DIGIT);

  logic [INT_W-1:0] qx, qy, rx_full, ry_full;
  logic [1:0]       rx, ry;
  dig_t             dig_next;

  assign qx      = div3_q(in_dig.ix);
  assign qy      = div3_q(in_dig.iy);
  assign rx_full = in_dig.ix - INT_W'({qx, 1'b0} + {1'b0, qx});
  assign ry_full = in_dig.iy - INT_W'({qy, 1'b0} + {1'b0, qy});
  assign rx      = rx_full[1:0];
  assign ry      = ry_full[1:0];

  always_comb begin
    dig_next    = in_dig;
    dig_next.ix = qx;
    dig_next.iy = qy;
    if (!in_dig.done) begin
      if (in_dig.ix == '0 && in_dig.iy == '0) begin
        dig_next.done = 1'b1;
      end else if (rx == 2'd1 && ry == 2'd1) begin
        dig_next.done  = 1'b1;
        dig_next.hit   = 1'b1;
        dig_next.depth = DIGIT_CODE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_dig <= dig_next;
    end
  end

endmodule

>>> sv/scp_color.sv
// Palette store and output register: palette writes land here in stream order.
module scp_color import scp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  dig_t in_dig,
  output logic out_valid,
  output out_t out_data
);

  logic [COLOR_W-1:0] palette [PAL_DEPTH];
  logic               is_write;
  out_t               out_next;

  assign is_write = (in_dig.req.command == CMD_PAL_WRITE);

  always_comb begin
    out_next.out_x     = in_dig.req.pixel_x;
    out_next.out_y     = in_dig.req.pixel_y;
    out_next.hit       = in_dig.hit;
    out_next.hit_depth = in_dig.hit ? in_dig.depth : '0;
    out_next.color     = in_dig.hit ? palette[in_dig.depth] : BLACK;
  end

  always_ff @(posedge clk) begin
    if (en && in_valid && is_write) begin
      palette[in_dig.req.palette_index] <= in_dig.req.palette_color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid && !is_write;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= out_next;
    end
  end

endmodule

>>> sv/sierpinski_carpet_pixel_top.sv
// Sierpinski carpet pixel colorer. Accepts one item per cycle while not stalled. Two stages
// map the pixel to a plane point (scale multiply, then offset add, saturate and absolute
// value), one stage per base-3 digit tests both integer parts, and a last stage reads the
// palette. Palette writes travel the same pipeline, take one slot and give no result, so
// they act in order with renders. A stall on a valid output freezes the whole pipeline and
// stalls the input in the same cycle.
module sierpinski_carpet_pixel_top import scp_pkg::*; #(
  parameter int WIDTH     = DEF_WIDTH,
  parameter int HEIGHT    = DEF_HEIGHT,
  parameter int MAX_DEPTH = DEF_MAX_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [CFG_W-1:0] step_x, step_y, offset_x, offset_y;
  logic             en;
  logic [MAX_DEPTH:0] dvalid;
  dig_t             dchain [MAX_DEPTH+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      step_x   <= STEP_RESET;
      step_y   <= STEP_RESET;
      offset_x <= OFFSET_RESET;
      offset_y <= OFFSET_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_STEP_X:   step_x   <= cfg_data;
        REG_STEP_Y:   step_y   <= cfg_data;
        REG_OFFSET_X: offset_x <= cfg_data;
        REG_OFFSET_Y: offset_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline moves whenever the output register is free or being drained
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  scp_map #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_map (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .in_req    (in_data),
    .step_x    (step_x),
    .step_y    (step_y),
    .offset_x  (offset_x),
    .offset_y  (offset_y),
    .out_valid (dvalid[0]),
    .out_dig   (dchain[0])
  );

  for (genvar k = 0; k < MAX_DEPTH; k++) begin : g_digit
    scp_digit #(
      .DIGIT (k)
    ) u_digit (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (dvalid[k]),
      .in_dig    (dchain[k]),
      .out_valid (dvalid[k+1]),
      .out_dig   (dchain[k+1])
    );
  end

  scp_color u_color (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (dvalid[MAX_DEPTH]),
    .in_dig    (dchain[MAX_DEPTH]),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`include "sierpinski_carpet_pixel_top_macros.svh"

  `SCP_ASSERT(a_miss_black, out_valid && !out_data.hit, out_data.color == BLACK && out_data.hit_depth == '0, "miss result is not black at depth zero")
  `SCP_ASSERT(a_depth_range, out_valid && out_data.hit, 32'(out_data.hit_depth) < MAX_DEPTH, "hit depth beyond last digit stage")
  `SCP_ASSERT_NEXT(a_freeze, in_stall, $stable(dvalid) && $stable(out_data), "pipeline moved while stalled")

endmodule
